// ----- src/coo_csr_pkg.sv -----
// ---------------------------------------------------------------------------
// COO to CSR converter package
// Shared codes, fixed widths and the control structs between the top level
// and the sequencer.
// ---------------------------------------------------------------------------
package coo_csr_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int ROW_BITS    = 10;
   localparam int IDX_BITS    = 11;
   localparam int ADDR_BITS   = 10;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_PTR   = 2'd1,
      FUNC_ENTRY = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // top level -> sequencer
   typedef struct packed {
      logic     start;
      func_type func;
      logic     out_free;
   } core_ctrl_type;

   // sequencer -> top level
   typedef struct packed {
      logic       ready;
      logic       done;
      status_type status;
   } core_stat_type;

endpackage

// ----- src/coo_csr_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module coo_csr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- src/coo_csr_core.sv -----
// ---------------------------------------------------------------------------
// COO to CSR sequencer
// Keeps the entry store ordered by (row, column) through an insertion pass
// on each load, and answers row pointer reads by a binary search over the
// stored entries. One RAM port pair is shared by all passes.
// ---------------------------------------------------------------------------
module coo_csr_core #(
   parameter int COL_BITS   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  coo_csr_pkg::core_ctrl_type     ctrl,
   output coo_csr_pkg::core_stat_type     stat,
   input  logic [coo_csr_pkg::IDX_BITS-1:0] rows_in_use,
   input  logic [coo_csr_pkg::ROW_BITS-1:0] entry_row,
   input  logic [COL_BITS-1:0]            entry_col,
   input  logic [VALUE_BITS-1:0]          entry_value,
   input  logic [coo_csr_pkg::IDX_BITS-1:0] read_index,
   output logic [coo_csr_pkg::IDX_BITS-1:0] out_pointer,
   output logic [coo_csr_pkg::ROW_BITS-1:0] out_row,
   output logic [COL_BITS-1:0]            out_col,
   output logic [VALUE_BITS-1:0]          out_value,
   output logic [coo_csr_pkg::IDX_BITS-1:0] out_count
);
   import coo_csr_pkg::*;

   localparam int KEY_W = ROW_BITS + COL_BITS;
   localparam int ENT_W = KEY_W + VALUE_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_INS_RD, S_INS_CMP, S_SRCH_RD, S_SRCH_CMP, S_ENT_RD, S_ENT_DATA, S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_BITS-1:0]  count_ff, count_in;
   logic [IDX_BITS-1:0]  k_ff, k_in;
   logic [IDX_BITS-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [ENT_W-1:0]     new_ff, new_in;
   logic [IDX_BITS-1:0]  idx_ff, idx_in;
   logic [IDX_BITS-1:0]  ptr_ff, ptr_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   status_type           status_ff, status_in;

   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [ENT_W-1:0]     wr_data, rd_data;
   logic [IDX_BITS:0]    mid_sum;

   coo_csr_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   // next state and datapath
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      new_in    = new_ff;
      idx_in    = idx_ff;
      ptr_in    = ptr_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      val_in    = val_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = k_ff[ADDR_BITS-1:0];
      wr_data   = new_ff;
      rd_addr   = '0;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               new_in    = {entry_value, entry_col, entry_row};
               idx_in    = read_index;
               ptr_in    = '0;
               row_in    = '0;
               col_in    = '0;
               val_in    = '0;
               status_in = STATUS_OK;
               state_in  = S_DONE;
               case (ctrl.func)
                  FUNC_LOAD: begin
                     if (count_ff >= IDX_BITS'(MAX_ENTRIES) ||
                         {1'b0, entry_row} >= rows_in_use) begin
                        status_in = STATUS_FULL;
                     end else begin
                        k_in     = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  FUNC_PTR: begin
                     if (read_index > rows_in_use) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        lo_in    = '0;
                        hi_in    = count_ff;
                        state_in = S_SRCH_RD;
                     end
                  end
                  FUNC_ENTRY: begin
                     if (read_index >= count_ff) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        state_in = S_ENT_RD;
                     end
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         // insertion: shift larger keys up one place
         S_INS_RD: begin
            if (k_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr  = ADDR_BITS'(k_ff - 1'b1);
               state_in = S_INS_CMP;
            end
         end
         // key is row then column; equal keys stay put
         S_INS_CMP: begin
            wr_en = 1'b1;
            if ({rd_data[ROW_BITS-1:0], rd_data[KEY_W-1:ROW_BITS]} >
                {new_ff[ROW_BITS-1:0], new_ff[KEY_W-1:ROW_BITS]}) begin
               wr_data  = rd_data;
               k_in     = k_ff - 1'b1;
               state_in = S_INS_RD;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end
         end
         // lower bound search of the row index
         S_SRCH_RD: begin
            if (lo_ff == hi_ff) begin
               ptr_in   = lo_ff;
               state_in = S_DONE;
            end else begin
               mid_in   = mid_sum[IDX_BITS:1];
               rd_addr  = ADDR_BITS'(mid_sum[IDX_BITS:1]);
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if ({1'b0, rd_data[ROW_BITS-1:0]} < idx_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SRCH_RD;
         end
         S_ENT_RD: begin
            rd_addr  = idx_ff[ADDR_BITS-1:0];
            state_in = S_ENT_DATA;
         end
         S_ENT_DATA: begin
            row_in   = rd_data[ROW_BITS-1:0];
            col_in   = rd_data[KEY_W-1:ROW_BITS];
            val_in   = rd_data[ENT_W-1:KEY_W];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (ctrl.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      k_ff      <= k_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      new_ff    <= new_in;
      idx_ff    <= idx_in;
      ptr_ff    <= ptr_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      val_ff    <= val_in;
      status_ff <= status_in;
   end

   assign stat.ready  = (state_ff == S_IDLE);
   assign stat.done   = (state_ff == S_DONE);
   assign stat.status = status_ff;
   assign out_pointer = ptr_ff;
   assign out_row     = row_ff;
   assign out_col     = col_ff;
   assign out_value   = val_ff;
   assign out_count   = count_ff;

endmodule

// ----- src/coo_to_csr_converter.sv -----
// ---------------------------------------------------------------------------
// COO to CSR converter, top level
// Stream wrapper: unpacks request words, holds the row count register and
// the response register.
// ---------------------------------------------------------------------------
// Entries are kept in (row, column) order at all times, equal keys in load
// order. A load is an insertion pass through the entry RAM that shifts each
// stored entry with a larger key up one place. A row pointer read is a binary
// search over the stored entries. One request is in work at a time; the
// response register lets the next request be taken while a response still
// waits, and a second finished response waits in the sequencer until the
// register frees.
module coo_to_csr_converter #(
   parameter int COL_BITS   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   // request: tdata = entry_row, entry_col, entry_value, read_index, zero pad
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [((21 + COL_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser = func
   input  logic [1:0]              req_tuser,
   // response: tdata = out_pointer, out_row, out_col, out_value, out_count, pad
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [((32 + COL_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // tuser = status
   output logic [1:0]              rsp_tuser,
   // num_rows register
   input  logic                    csr_wr_en,
   input  logic [coo_csr_pkg::IDX_BITS-1:0] csr_wr_data
);
   import coo_csr_pkg::*;

   localparam int RSP_W  = ((32 + COL_BITS + VALUE_BITS + 7) / 8) * 8;
   localparam int COL_LO = ROW_BITS;
   localparam int VAL_LO = COL_LO + COL_BITS;
   localparam int IDX_LO = VAL_LO + VALUE_BITS;

   core_ctrl_type          ctrl;
   core_stat_type          stat;
   logic [IDX_BITS-1:0]    num_rows_ff, rows_in_use;
   logic [IDX_BITS-1:0]    c_pointer, c_count;
   logic [ROW_BITS-1:0]    c_row;
   logic [COL_BITS-1:0]    c_col;
   logic [VALUE_BITS-1:0]  c_value;
   logic                   rsp_valid_ff;
   logic [RSP_W-1:0]       rsp_data_ff;
   logic [1:0]             rsp_user_ff;

   // row count in use, clamped to 1..MAX_ROWS
   always_comb begin
      if (num_rows_ff == '0) begin
         rows_in_use = IDX_BITS'(1);
      end else if (num_rows_ff > IDX_BITS'(MAX_ROWS)) begin
         rows_in_use = IDX_BITS'(MAX_ROWS);
      end else begin
         rows_in_use = num_rows_ff;
      end
   end

   assign req_tready    = stat.ready;
   assign ctrl.start    = req_tvalid && stat.ready;
   assign ctrl.func     = func_type'(req_tuser);
   assign ctrl.out_free = !rsp_valid_ff || rsp_tready;

   coo_csr_core #(.COL_BITS(COL_BITS), .VALUE_BITS(VALUE_BITS)) u_core (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .stat        (stat),
      .rows_in_use (rows_in_use),
      .entry_row   (req_tdata[ROW_BITS-1:0]),
      .entry_col   (req_tdata[VAL_LO-1:COL_LO]),
      .entry_value (req_tdata[IDX_LO-1:VAL_LO]),
      .read_index  (req_tdata[IDX_LO+IDX_BITS-1:IDX_LO]),
      .out_pointer (c_pointer),
      .out_row     (c_row),
      .out_col     (c_col),
      .out_value   (c_value),
      .out_count   (c_count)
   );

   // register and response word
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff  <= IDX_BITS'(MAX_ROWS);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            num_rows_ff <= csr_wr_data;
         end
         if (stat.done && ctrl.out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (stat.done && ctrl.out_free) begin
         rsp_data_ff <= RSP_W'({c_count, c_value, c_col, c_row, c_pointer});
         rsp_user_ff <= stat.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- src/coo_csr_checker.sv -----
// ---------------------------------------------------------------------------
// COO to CSR converter port checker
// Watches the top level's ports and is bound to every instance.
// ---------------------------------------------------------------------------
module coo_csr_checker #(
   parameter int COL_BITS   = 16,
   parameter int VALUE_BITS = 32
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((32 + COL_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   input logic [1:0] rsp_tuser
);
   import coo_csr_pkg::*;

   localparam int CNT_LO = 21 + COL_BITS + VALUE_BITS;

   // stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // no response straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // status never takes the unused code
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("bad status code");

   // entry count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[CNT_LO+IDX_BITS-1:CNT_LO] <= IDX_BITS'(MAX_ENTRIES))
      else $error("entry count beyond capacity");

   // an accepted request drops ready while it is worked on
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready held through a request");

endmodule

bind coo_to_csr_converter coo_csr_checker #(
   .COL_BITS(COL_BITS), .VALUE_BITS(VALUE_BITS)
) u_coo_csr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
